// File: hw/rtl/clock_seven_segment_scan_driver_macros.svh
// ----------------------------------------------------------------------------
// Seven-segment clock driver assertion macros
// Shared concurrent assertion forms used by the clock driver RTL.
// ----------------------------------------------------------------------------
`ifndef CLOCK_SEVEN_SEGMENT_SCAN_DRIVER_MACROS_SVH
`define CLOCK_SEVEN_SEGMENT_SCAN_DRIVER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CLK7SEG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define CLK7SEG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/clk7seg_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment clock driver package
// Widths, reset values, register indexes and decode helpers.
// ----------------------------------------------------------------------------
package clk7seg_pkg;

  localparam int CountWidth = 10;
  localparam int NumDigits  = 4;
  localparam int IdxWidth   = $clog2(NumDigits);
  localparam int CfgAddrWidth = 2;
  localparam int OutWidth   = 32;

  typedef logic [CountWidth-1:0] count_t;

  // Configuration register indexes.
  localparam logic [CfgAddrWidth-1:0] RegDotPeriod   = 2'd0;
  localparam logic [CfgAddrWidth-1:0] RegScanPeriod  = 2'd1;
  localparam logic [CfgAddrWidth-1:0] RegClockPeriod = 2'd2;

  localparam count_t DotPeriodReset   = CountWidth'(100);
  localparam count_t ScanPeriodReset  = CountWidth'(25);
  localparam count_t ClockPeriodReset = CountWidth'(100);

  localparam logic [4:0] HourReset   = 5'd15;
  localparam logic [5:0] MinuteReset = 6'd12;
  localparam logic [5:0] SecondReset = 6'd37;
  localparam logic [5:0] SecondsPerMinute = 6'd60;
  localparam logic [5:0] MinutesPerHour   = 6'd60;
  localparam logic [4:0] HoursPerDay      = 5'd24;

  // One flag per counter that expired on the current tick.
  typedef struct packed {
    logic dot;
    logic scan;
    logic sec;
  } fire_t;

  // Tens digit of a value below 64.
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [3:0] t;
    if (v >= 6'd60)      t = 4'd6;
    else if (v >= 6'd50) t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else                 t = 4'd0;
    return t;
  endfunction

  function automatic logic [3:0] units_of(input logic [5:0] v);
    logic [6:0] tens_x10;
    logic [6:0] diff;
    tens_x10 = 7'(tens_of(v)) * 7'd10;
    diff     = {1'b0, v} - tens_x10;
    return diff[3:0];
  endfunction

  // Active-high segment pattern, bit 0 = A up to bit 6 = G.
  function automatic logic [6:0] seg_pattern(input logic [3:0] d);
    logic [6:0] p;
    unique case (d)
      4'd0: p = 7'h3F;
      4'd1: p = 7'h06;
      4'd2: p = 7'h5B;
      4'd3: p = 7'h4F;
      4'd4: p = 7'h66;
      4'd5: p = 7'h6D;
      4'd6: p = 7'h7D;
      4'd7: p = 7'h07;
      4'd8: p = 7'h7F;
      default: p = 7'h6F;
    endcase
    return p;
  endfunction

endpackage

// File: hw/rtl/clk7seg_timers.sv
// ----------------------------------------------------------------------------
// Seven-segment clock driver timers
// Period registers, three tick down-counters and the colon dot level.
// ----------------------------------------------------------------------------
module clk7seg_timers import clk7seg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CfgAddrWidth-1:0] cfg_addr,
  input  logic [CountWidth-1:0]   cfg_data,
  input  logic                    step,
  output fire_t                   fire,
  output logic                    dot_next
);

  count_t dot_period, scan_period, clock_period;
  count_t dot_count, scan_count, second_count;
  count_t dot_count_next, scan_count_next, second_count_next;
  logic   dot_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_period   <= DotPeriodReset;
      scan_period  <= ScanPeriodReset;
      clock_period <= ClockPeriodReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        RegDotPeriod:   dot_period   <= cfg_data;
        RegScanPeriod:  scan_period  <= cfg_data;
        RegClockPeriod: clock_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // A count of one or zero expires and reloads, so a period of zero acts as one.
  always_comb begin
    fire.dot  = dot_count    <= count_t'(1);
    fire.scan = scan_count   <= count_t'(1);
    fire.sec  = second_count <= count_t'(1);
    dot_count_next    = fire.dot  ? dot_period   : dot_count    - count_t'(1);
    scan_count_next   = fire.scan ? scan_period  : scan_count   - count_t'(1);
    second_count_next = fire.sec  ? clock_period : second_count - count_t'(1);
    dot_next = dot_level ^ (step & fire.dot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_count    <= DotPeriodReset;
      scan_count   <= ScanPeriodReset;
      second_count <= ClockPeriodReset;
      dot_level    <= 1'b1;
    end else if (step) begin
      dot_count    <= dot_count_next;
      scan_count   <= scan_count_next;
      second_count <= second_count_next;
      dot_level    <= dot_next;
    end
  end

endmodule

// File: hw/rtl/clk7seg_clock.sv
// ----------------------------------------------------------------------------
// Seven-segment clock driver time of day
// Hours, minutes and seconds with wrap at 24, 60 and 60.
// ----------------------------------------------------------------------------
module clk7seg_clock import clk7seg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  output logic [4:0] hour_reg,
  output logic [5:0] minute_reg,
  output logic [5:0] second_reg,
  output logic [4:0] hour_next,
  output logic [5:0] minute_next,
  output logic [5:0] second_next
);

  logic [5:0] sec_inc, min_inc;
  logic [4:0] hour_inc;
  logic       sec_wrap, min_wrap;

  always_comb begin
    sec_inc  = second_reg + 6'd1;
    sec_wrap = sec_inc >= SecondsPerMinute;
    min_inc  = minute_reg + 6'(sec_wrap);
    min_wrap = min_inc >= MinutesPerHour;
    hour_inc = hour_reg + 5'(min_wrap);
    if (advance) begin
      second_next = sec_wrap ? 6'd0 : sec_inc;
      minute_next = min_wrap ? 6'd0 : min_inc;
      hour_next   = (hour_inc >= HoursPerDay) ? 5'd0 : hour_inc;
    end else begin
      second_next = second_reg;
      minute_next = minute_reg;
      hour_next   = hour_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_reg   <= HourReset;
      minute_reg <= MinuteReset;
      second_reg <= SecondReset;
    end else begin
      hour_reg   <= hour_next;
      minute_reg <= minute_next;
      second_reg <= second_next;
    end
  end

endmodule

// File: hw/rtl/clk7seg_scan.sv
// ----------------------------------------------------------------------------
// Seven-segment clock driver digit scan
// Steps through the four digits and drives active-low enables and segments.
// ----------------------------------------------------------------------------
module clk7seg_scan import clk7seg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [4:0] hour_reg,
  input  logic [5:0] minute_reg,
  output logic [6:0] segment_next,
  output logic [3:0] enable_next
);

  logic [IdxWidth-1:0] scan_index;
  logic [6:0]          segment_reg;
  logic [3:0]          enable_reg;
  logic [3:0]          digit;

  // The digit shows the time as it stood before this tick's clock step.
  always_comb begin
    unique case (scan_index)
      2'd0:    digit = tens_of({1'b0, hour_reg});
      2'd1:    digit = units_of({1'b0, hour_reg});
      2'd2:    digit = tens_of(minute_reg);
      default: digit = units_of(minute_reg);
    endcase
    if (digit > 4'd9) digit = 4'd9;
    if (advance) begin
      segment_next = ~seg_pattern(digit);
      enable_next  = ~(4'd1 << scan_index);
    end else begin
      segment_next = segment_reg;
      enable_next  = enable_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_index  <= '0;
      segment_reg <= '0;
      enable_reg  <= '0;
    end else begin
      segment_reg <= segment_next;
      enable_reg  <= enable_next;
      if (advance) scan_index <= scan_index + IdxWidth'(1);
    end
  end

endmodule

// File: hw/rtl/clk7seg_obuf.sv
// ----------------------------------------------------------------------------
// Seven-segment clock driver output buffer
// Output register with one skid entry that takes one item during a stall.
// ----------------------------------------------------------------------------
module clk7seg_obuf import clk7seg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [OutWidth-1:0] in_data,
  output logic                in_ready,
  output logic                out_valid,
  output logic [OutWidth-1:0] out_data,
  input  logic                out_ready
);

  logic                skid_valid;
  logic [OutWidth-1:0] skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (in_valid) skid_valid <= 1'b1;
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (in_valid) skid_data <= in_data;
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (in_valid) begin
      out_data <= in_data;
    end
  end

endmodule

// File: hw/rtl/clock_seven_segment_scan_driver.sv
// ----------------------------------------------------------------------------
// Multiplexed four-digit seven-segment clock driver
// Tick-driven colon dot, digit scan and time of day with a stream result.
// ----------------------------------------------------------------------------
// Usage: each item on the s_ side carries one bit, tick. A tick of one
// advances three down-counters (dot, scan and clock second); a tick of zero
// holds all state. Every accepted item yields exactly one result item on the
// m_ side holding the segment and digit enable pins, the dot level and the
// current hours, minutes and seconds after that item's update.
// A result is registered in the output register, or in the skid entry
// while the receiver stalls. One item is taken per cycle while s_tready
// is high, in a single registered pass through counters and digit decode.
// When the receiver stalls, the output register holds its result and a skid
// entry takes one more item; s_tready falls only while that entry is full.
// Reset brings the time to 15:12:37, the dot high, all pins low and the
// periods to 100, 25 and 100 ticks. Periods are written through cfg_we,
// cfg_addr and cfg_data; a new period takes effect at the next reload.
// ----------------------------------------------------------------------------
`include "clock_seven_segment_scan_driver_macros.svh"

module clock_seven_segment_scan_driver import clk7seg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [7:0]              s_tdata,   // [0] tick, [7:1] zero
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // [6:0] segments, [10:7] digit_enable, [11] dot, [16:12] hours,
  // [22:17] minutes, [28:23] seconds, [31:29] zero
  output logic [OutWidth-1:0]     m_tdata,
  input  logic                    cfg_we,
  input  logic [CfgAddrWidth-1:0] cfg_addr,
  input  logic [CountWidth-1:0]   cfg_data
);

  logic          accept;
  logic          step;
  fire_t         fire;
  logic          dot_next;
  logic [4:0]    hour_reg, hour_next;
  logic [5:0]    minute_reg, minute_next;
  logic [5:0]    second_reg, second_next;
  logic [6:0]    segment_next;
  logic [3:0]    enable_next;
  logic [OutWidth-1:0] result;

  assign accept = s_tvalid && s_tready;
  // Only an accepted item with its tick bit set moves any state.
  assign step   = accept && s_tdata[0];

  clk7seg_timers u_timers (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .step     (step),
    .fire     (fire),
    .dot_next (dot_next)
  );

  // The scan reads the time before this tick's clock step, matching the
  // dot, scan, clock order of work within one tick.
  clk7seg_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .advance      (step && fire.scan),
    .hour_reg     (hour_reg),
    .minute_reg   (minute_reg),
    .segment_next (segment_next),
    .enable_next  (enable_next)
  );

  clk7seg_clock u_clock (
    .clk         (clk),
    .rst         (rst),
    .advance     (step && fire.sec),
    .hour_reg    (hour_reg),
    .minute_reg  (minute_reg),
    .second_reg  (second_reg),
    .hour_next   (hour_next),
    .minute_next (minute_next),
    .second_next (second_next)
  );

  assign result = {3'b000, second_next, minute_next, hour_next, dot_next,
                   enable_next, segment_next};

  clk7seg_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_data   (result),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_ready (m_tready)
  );

  `CLK7SEG_ASSERT(a_time_range, (second_reg < 6'd60) && (minute_reg < 6'd60) && (hour_reg < 5'd24), "time out of range")
  `CLK7SEG_ASSERT(a_scan_one_digit, !(step && fire.scan) || ($countones(enable_next) == 3), "scan lit not one digit")
  `CLK7SEG_ASSERT_NEXT(a_result_follows, accept, m_tvalid, "accepted item gave no result")
  `CLK7SEG_ASSERT_NEXT(a_hold_no_tick, accept && !s_tdata[0], $stable(hour_reg) && $stable(minute_reg) && $stable(second_reg), "time moved without a tick")

endmodule
